// ===== rtl/core/idm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idm_pkg
// Shared constants, codes and types of the image distortion model distance.
// ----------------------------------------------------------------------------
package idm_pkg;

   localparam int IMG_SIDE = 30;
   localparam int MAX_WARP = 7;
   localparam int PIX_CNT  = IMG_SIDE * IMG_SIDE;

   localparam int GW      = 11;                    // gradient width
   localparam int WARP_W  = 3;                     // warp register width
   localparam int XW      = $clog2(IMG_SIDE);      // coordinate width
   localparam int CW      = $clog2(IMG_SIDE + 2);  // coordinate plus one
   localparam int SW      = XW + WARP_W + 1;       // window bound arithmetic
   localparam int AW      = $clog2(PIX_CNT);       // store address width
   localparam int SQ1_W   = 2 * GW;                // one squared difference
   localparam int SQ_W    = SQ1_W + 1;             // h plus v squares
   localparam int PATCH_W = SQ_W + 4;              // nine positions
   localparam int DW      = 37;                    // distance width

   localparam logic [DW-1:0]     DIST_ONES  = {DW{1'b1}};
   localparam logic [WARP_W-1:0] WARP_RESET = WARP_W'(3);

   localparam logic [1:0] ACT_TEST   = 2'd0;
   localparam logic [1:0] ACT_TRAIN  = 2'd1;
   localparam logic [1:0] ACT_REPORT = 2'd2;

   typedef struct packed {
      logic          wr_test;
      logic          wr_train;
      logic          start;
      logic [AW-1:0] addr;
      logic [GW-1:0] grad_h;
      logic [GW-1:0] grad_v;
   } ctrl_type;

   typedef struct packed {
      logic          valid;
      logic [DW-1:0] value;
   } link_type;

endpackage
`default_nettype wire

// ===== rtl/core/idm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idm_req_if / idm_rsp_if
// Valid/ready channels for pixel items and best-three reports.
// ----------------------------------------------------------------------------
interface idm_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 action;
   logic signed [idm_pkg::GW-1:0] grad_h;
   logic signed [idm_pkg::GW-1:0] grad_v;
   modport source (output valid, action, grad_h, grad_v, input ready);
   modport sink   (input valid, action, grad_h, grad_v, output ready);
endinterface

interface idm_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [idm_pkg::DW-1:0]  best_first;
   logic [idm_pkg::DW-1:0]  best_second;
   logic [idm_pkg::DW-1:0]  best_third;
   modport source (output valid, best_first, best_second, best_third, input ready);
   modport sink   (input valid, best_first, best_second, best_third, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/image_distortion_model_knn_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A load item goes into its store on transfer; a report shows on the output the cycle after.
// The last training pixel starts a sweep: for every pixel, each candidate in its clipped
//   window is scored over its 3x3 context, and the least score is summed into the total.
// The sweep uses the single read port of each gradient store; no item is taken meanwhile.
// Reset (synchronous, active high) clears fill counts, kept totals to all ones, warp_range to 3.
// ----------------------------------------------------------------------------
// image_distortion_model_knn_distance
// Image distortion model distance with a chain of three best-total cells.
// ----------------------------------------------------------------------------
module image_distortion_model_knn_distance (
   input  wire logic                       clock,
   input  wire logic                       reset,
   idm_req_if.sink                         req_bus,
   idm_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_wr_en,
   input  wire logic [idm_pkg::WARP_W-1:0] csr_wr_data
);

   localparam int AW = idm_pkg::AW;
   localparam logic [AW-1:0] LAST_PIX = AW'(idm_pkg::PIX_CNT - 1);

   logic [idm_pkg::WARP_W-1:0] warp_ff;
   logic                       busy_ff, busy_in;
   logic [AW-1:0]              test_cnt_ff, test_cnt_in, train_cnt_ff, train_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [idm_pkg::DW-1:0]     first_ff, second_ff, third_ff;
   logic                       xfer, is_test, is_train, is_report;
   idm_pkg::ctrl_type          ctrl;
   idm_pkg::link_type          total;
   idm_pkg::link_type          link [4];
   logic [idm_pkg::DW-1:0]     held [3];

   // hold every item back during a sweep, and a report also while the previous one still waits
   assign req_bus.ready = !busy_ff &&
                          ((req_bus.action != idm_pkg::ACT_REPORT) || !rsp_valid_ff ||
                           rsp_bus.ready);
   assign xfer      = req_bus.valid && req_bus.ready;
   assign is_test   = xfer && (req_bus.action == idm_pkg::ACT_TEST);
   assign is_train  = xfer && (req_bus.action == idm_pkg::ACT_TRAIN);
   assign is_report = xfer && (req_bus.action == idm_pkg::ACT_REPORT);

   always_comb begin
      ctrl.wr_test  = is_test;
      ctrl.wr_train = is_train;
      ctrl.start    = is_train && (train_cnt_ff == LAST_PIX);
      ctrl.addr     = is_test ? test_cnt_ff : train_cnt_ff;
      ctrl.grad_h   = req_bus.grad_h;
      ctrl.grad_v   = req_bus.grad_v;
   end

   // fill counters wrap at the image size; a report restarts both
   always_comb begin
      test_cnt_in  = test_cnt_ff;
      train_cnt_in = train_cnt_ff;
      if (is_report) begin
         test_cnt_in  = '0;
         train_cnt_in = '0;
      end else if (is_test) begin
         test_cnt_in = (test_cnt_ff == LAST_PIX) ? '0 : test_cnt_ff + AW'(1);
      end else if (is_train) begin
         train_cnt_in = (train_cnt_ff == LAST_PIX) ? '0 : train_cnt_ff + AW'(1);
      end
   end

   // busy from the start of a sweep until the total has left the last cell
   always_comb begin
      busy_in = busy_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
      end else if (link[3].valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (is_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_ff      <= idm_pkg::WARP_RESET;
         busy_ff      <= 1'b0;
         test_cnt_ff  <= '0;
         train_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            warp_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         test_cnt_ff  <= test_cnt_in;
         train_cnt_ff <= train_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (is_report) begin
         first_ff  <= held[0];
         second_ff <= held[1];
         third_ff  <= held[2];
      end
   end

   idm_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .warp  (warp_ff),
      .total (total)
   );

   // the total ripples down the row; each cell keeps the smaller value, drop what leaves
   assign link[0] = total;

   for (genvar i = 0; i < 3; i++) begin : g_cell
      idm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (is_report),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .held     (held[i])
      );
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.best_first  = first_ff;
   assign rsp_bus.best_second = second_ff;
   assign rsp_bus.best_third  = third_ff;

   // no transfer in while a sweep runs
   a_no_xfer_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !xfer)
      else $error("input transfer during sweep");

   // a finished total only appears inside a sweep
   a_total_busy: assert property (@(posedge clock) disable iff (reset)
      total.valid |-> busy_ff)
      else $error("total outside sweep");

   // kept totals stay in ascending order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (held[0] <= held[1]) && (held[1] <= held[2]))
      else $error("kept totals out of order");

endmodule
`default_nettype wire

// ===== rtl/core/idm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idm_cell
// One insertion-sort cell: keep the smaller value, pass the other on.
// ----------------------------------------------------------------------------
module idm_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire idm_pkg::link_type link_in,
   output idm_pkg::link_type      link_out,
   output logic [idm_pkg::DW-1:0] held
);

   logic [idm_pkg::DW-1:0] held_ff, held_in;
   idm_pkg::link_type      out_ff, out_in;

   always_comb begin
      held_in      = held_ff;
      out_in.valid = link_in.valid;
      out_in.value = link_in.value;
      if (clear) begin
         held_in      = idm_pkg::DIST_ONES;
         out_in.valid = 1'b0;
      end else if (link_in.valid && (link_in.value < held_ff)) begin
         held_in      = link_in.value;
         out_in.value = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= idm_pkg::DIST_ONES;
         out_ff.valid <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_ff.valid <= out_in.valid;
      end
      out_ff.value <= out_in.value;
   end

   assign link_out = out_ff;
   assign held     = held_ff;

endmodule
`default_nettype wire

// ===== rtl/core/idm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idm_engine
// Gradient stores, window sequencer and patch score pipeline.
// ----------------------------------------------------------------------------
module idm_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire idm_pkg::ctrl_type         ctrl,
   input  wire logic [idm_pkg::WARP_W-1:0] warp,
   output idm_pkg::link_type              total
);

   typedef struct packed {
      logic in_both;
      logic nb_first;
      logic nb_last;
      logic cand_first;
      logic cand_last;
      logic img_last;
   } flag_type;

   localparam int XW = idm_pkg::XW;
   localparam int CW = idm_pkg::CW;
   localparam int SW = idm_pkg::SW;
   localparam int AW = idm_pkg::AW;
   localparam int GW = idm_pkg::GW;
   localparam int PW = idm_pkg::PATCH_W;
   localparam int DW = idm_pkg::DW;
   localparam logic [XW-1:0] LAST_XY = XW'(idm_pkg::IMG_SIDE - 1);

   logic [2*GW-1:0] test_mem  [idm_pkg::PIX_CNT];
   logic [2*GW-1:0] train_mem [idm_pkg::PIX_CNT];

   logic [idm_pkg::WARP_W-1:0] w_eff;

   function automatic logic [XW-1:0] win_lo(input logic [XW-1:0] v,
                                            input logic [idm_pkg::WARP_W-1:0] w);
      logic [XW-1:0] r;
      r = (SW'(v) >= SW'(w)) ? XW'(SW'(v) - SW'(w)) : '0;
      return r;
   endfunction

   function automatic logic [XW-1:0] win_hi(input logic [XW-1:0] v,
                                            input logic [idm_pkg::WARP_W-1:0] w);
      logic [SW-1:0] s;
      s = SW'(v) + SW'(w);
      return (s > SW'(idm_pkg::IMG_SIDE - 1)) ? LAST_XY : XW'(s);
   endfunction

   // sequencer
   logic          run_ff, run_in;
   logic [XW-1:0] x_ff, x_in, y_ff, y_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [XW-1:0] lox, hix, loy, hiy;
   flag_type      f0;
   logic [AW-1:0] pa, pb;
   logic [CW-1:0] tr_p1, tc_p1, br_p1, bc_p1;

   assign w_eff = (SW'(warp) > SW'(idm_pkg::MAX_WARP)) ?
                  idm_pkg::WARP_W'(idm_pkg::MAX_WARP) : warp;
   assign lox = win_lo(x_ff, w_eff);
   assign hix = win_hi(x_ff, w_eff);
   assign loy = win_lo(y_ff, w_eff);
   assign hiy = win_hi(y_ff, w_eff);

   function automatic logic in_img(input logic [CW-1:0] p1);
      return (p1 != '0) && (p1 <= CW'(idm_pkg::IMG_SIDE));
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r1,
                                             input logic [CW-1:0] c1);
      return AW'(AW'(r1 - CW'(1)) * AW'(idm_pkg::IMG_SIDE)) + AW'(c1 - CW'(1));
   endfunction

   always_comb begin
      tr_p1 = CW'(y_ff) + CW'(dy_ff);
      tc_p1 = CW'(x_ff) + CW'(dx_ff);
      br_p1 = CW'(cy_ff) + CW'(dy_ff);
      bc_p1 = CW'(cx_ff) + CW'(dx_ff);
      pa    = addr_of(tr_p1, tc_p1);
      pb    = addr_of(br_p1, bc_p1);
      f0.in_both    = in_img(tr_p1) && in_img(tc_p1) && in_img(br_p1) && in_img(bc_p1);
      f0.nb_first   = (dx_ff == 2'd0) && (dy_ff == 2'd0);
      f0.nb_last    = (dx_ff == 2'd2) && (dy_ff == 2'd2);
      f0.cand_first = (cx_ff == lox) && (cy_ff == loy);
      f0.cand_last  = f0.nb_last && (cx_ff == hix) && (cy_ff == hiy);
      f0.img_last   = f0.cand_last && (x_ff == LAST_XY) && (y_ff == LAST_XY);
   end

   always_comb begin
      run_in = run_ff;
      x_in = x_ff; y_in = y_ff; cx_in = cx_ff; cy_in = cy_ff;
      dx_in = dx_ff; dy_in = dy_ff;
      if (ctrl.start) begin
         run_in = 1'b1;
         x_in = '0; y_in = '0; cx_in = '0; cy_in = '0; dx_in = '0; dy_in = '0;
      end else if (run_ff) begin
         if (!f0.nb_last) begin
            // advance over the 3x3 context
            if (dx_ff != 2'd2) begin
               dx_in = dx_ff + 2'd1;
            end else begin
               dx_in = '0;
               dy_in = dy_ff + 2'd1;
            end
         end else begin
            dx_in = '0;
            dy_in = '0;
            if (cx_ff != hix) begin
               cx_in = cx_ff + XW'(1);
            end else if (cy_ff != hiy) begin
               cx_in = lox;
               cy_in = cy_ff + XW'(1);
            end else if (f0.img_last) begin
               run_in = 1'b0;
            end else begin
               if (x_ff != LAST_XY) begin
                  x_in = x_ff + XW'(1);
               end else begin
                  x_in = '0;
                  y_in = y_ff + XW'(1);
               end
               cx_in = win_lo(x_in, w_eff);
               cy_in = win_lo(y_in, w_eff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      x_ff <= x_in; y_ff <= y_in; cx_ff <= cx_in; cy_ff <= cy_in;
      dx_ff <= dx_in; dy_ff <= dy_in;
   end

   // stores, read data registered
   logic [2*GW-1:0] ta_ff, tb_ff;
   logic            s1_act_ff;
   flag_type        s1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_test) begin
         test_mem[ctrl.addr] <= {ctrl.grad_h, ctrl.grad_v};
      end
      if (ctrl.wr_train) begin
         train_mem[ctrl.addr] <= {ctrl.grad_h, ctrl.grad_v};
      end
      ta_ff <= test_mem[pa];
      tb_ff <= train_mem[pb];
      s1_ff <= f0;
   end

   // squared differences
   logic signed [GW:0]       eh, ev;
   logic signed [2*GW+1:0]   ph, pv;
   logic [idm_pkg::SQ_W-1:0] sq_ff;
   logic                     s2_act_ff;
   flag_type                 s2_ff;

   always_comb begin
      eh = $signed({ta_ff[2*GW-1], ta_ff[2*GW-1:GW]}) -
           $signed({tb_ff[2*GW-1], tb_ff[2*GW-1:GW]});
      ev = $signed({ta_ff[GW-1], ta_ff[GW-1:0]}) - $signed({tb_ff[GW-1], tb_ff[GW-1:0]});
      ph = eh * eh;
      pv = ev * ev;
   end

   always_ff @(posedge clock) begin
      sq_ff <= s1_ff.in_both ?
               idm_pkg::SQ_W'(ph[idm_pkg::SQ1_W-1:0]) +
               idm_pkg::SQ_W'(pv[idm_pkg::SQ1_W-1:0]) : '0;
      s2_ff <= s1_ff;
   end

   // patch accumulate, then minimum over the window, then image total
   logic [PW-1:0] acc_ff, acc_in, score_ff, minb_ff, minb_in, pix_ff;
   logic          s3_act_ff, s4_act_ff, s3_first_ff, s3_last_ff, s3_img_ff, s4_img_ff;
   logic [DW-1:0] tot_ff, tot_in;
   logic [DW:0]   tot_sum;

   assign acc_in  = (s2_ff.nb_first ? '0 : acc_ff) + PW'(sq_ff);
   assign minb_in = (s3_first_ff || (score_ff < minb_ff)) ? score_ff : minb_ff;
   assign tot_sum = (DW+1)'(tot_ff) + (DW+1)'(pix_ff);
   assign tot_in  = tot_sum[DW] ? idm_pkg::DIST_ONES : tot_sum[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff   <= 1'b0;
         s2_act_ff   <= 1'b0;
         s3_act_ff   <= 1'b0;
         s4_act_ff   <= 1'b0;
         total.valid <= 1'b0;
      end else begin
         s1_act_ff   <= run_ff;
         s2_act_ff   <= s1_act_ff;
         s3_act_ff   <= s2_act_ff && s2_ff.nb_last;
         s4_act_ff   <= s3_act_ff && s3_last_ff;
         total.valid <= s4_act_ff && s4_img_ff;
      end
      if (s2_act_ff) begin
         acc_ff <= acc_in;
      end
      if (s2_act_ff && s2_ff.nb_last) begin
         score_ff    <= acc_in;
         s3_first_ff <= s2_ff.cand_first;
         s3_last_ff  <= s2_ff.cand_last;
         s3_img_ff   <= s2_ff.img_last;
      end
      if (s3_act_ff) begin
         minb_ff <= minb_in;
      end
      if (s3_act_ff && s3_last_ff) begin
         pix_ff    <= minb_in;
         s4_img_ff <= s3_img_ff;
      end
      if (ctrl.start) begin
         tot_ff <= '0;
      end else if (s4_act_ff) begin
         tot_ff <= tot_in;
      end
      total.value <= tot_in;
   end

endmodule
`default_nettype wire

// ===== dv/idm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idm_checker
// Watches the pixel and report channels and predicts each best-three report.
// Compares every report, field by field, and counts the failures.
// ----------------------------------------------------------------------------
module idm_checker import idm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   idm_req_if                req,
   idm_rsp_if                rsp,
   input  logic              csr_wr_en,
   input  logic [WARP_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending
);

   typedef struct {
      logic [DW-1:0] first;
      logic [DW-1:0] second;
      logic [DW-1:0] third;
   } best_set_type;

   logic signed [GW-1:0] test_h  [PIX_CNT];
   logic signed [GW-1:0] test_v  [PIX_CNT];
   logic signed [GW-1:0] train_h [PIX_CNT];
   logic signed [GW-1:0] train_v [PIX_CNT];
   int                   test_fill;
   int                   train_fill;
   logic [DW-1:0]        kept [3];
   logic [WARP_W-1:0]    warp;
   best_set_type         reports_due [$];

   assign pending = reports_due.size();

   function automatic bit on_grid(int a);
      return a >= 0 && a < IMG_SIDE;
   endfunction

   function automatic longint unsigned patch_cost(int tx, int ty, int bx, int by);
      longint unsigned acc;
      longint          eh;
      longint          ev;
      int              pa;
      int              pb;
      acc = 0;
      for (int dx = -1; dx <= 1; dx++) begin
         for (int dy = -1; dy <= 1; dy++) begin
            if (on_grid(tx + dx) && on_grid(ty + dy) && on_grid(bx + dx) && on_grid(by + dy)) begin
               pa  = (ty + dy) * IMG_SIDE + (tx + dx);
               pb  = (by + dy) * IMG_SIDE + (bx + dx);
               eh  = longint'(test_h[pa]) - longint'(train_h[pb]);
               ev  = longint'(test_v[pa]) - longint'(train_v[pb]);
               acc += eh * eh + ev * ev;
            end
         end
      end
      return acc;
   endfunction

   function automatic longint unsigned warped_distance();
      longint unsigned total;
      longint unsigned least;
      longint unsigned s;
      int              w;
      w     = (warp > MAX_WARP) ? MAX_WARP : int'(warp);
      total = 0;
      for (int y = 0; y < IMG_SIDE; y++) begin
         for (int x = 0; x < IMG_SIDE; x++) begin
            least = patch_cost(x, y, x, y);
            for (int cx = x - w; cx <= x + w; cx++) begin
               for (int cy = y - w; cy <= y + w; cy++) begin
                  if (on_grid(cx) && on_grid(cy)) begin
                     s = patch_cost(x, y, cx, cy);
                     if (s < least) least = s;
                  end
               end
            end
            total += least;
            if (total > DIST_ONES) total = DIST_ONES;
         end
      end
      return total;
   endfunction

   // strict less-than: ties and saturated totals never displace a kept entry
   function automatic void rank_distance(logic [DW-1:0] d);
      if (d < kept[0]) begin
         kept[2] = kept[1];
         kept[1] = kept[0];
         kept[0] = d;
      end else if (d < kept[1]) begin
         kept[2] = kept[1];
         kept[1] = d;
      end else if (d < kept[2]) begin
         kept[2] = d;
      end
   endfunction

   always @(posedge clock) begin
      best_set_type exp_set;
      if (reset) begin
         test_fill  = 0;
         train_fill = 0;
         kept       = '{DIST_ONES, DIST_ONES, DIST_ONES};
         warp       = WARP_RESET;
         fail_count = 0;
         reports_due.delete();
      end else begin
         if (csr_wr_en) warp = csr_wr_data;
         if (req.valid && req.ready) begin
            case (req.action)
               ACT_TEST: begin
                  test_h[test_fill] = req.grad_h;
                  test_v[test_fill] = req.grad_v;
                  test_fill = (test_fill + 1) % PIX_CNT;
               end
               ACT_TRAIN: begin
                  train_h[train_fill] = req.grad_h;
                  train_v[train_fill] = req.grad_v;
                  if (train_fill == PIX_CNT - 1) begin
                     train_fill = 0;
                     rank_distance(DW'(warped_distance()));
                  end else begin
                     train_fill++;
                  end
               end
               ACT_REPORT: begin
                  exp_set.first  = kept[0];
                  exp_set.second = kept[1];
                  exp_set.third  = kept[2];
                  reports_due.push_back(exp_set);
                  kept       = '{DIST_ONES, DIST_ONES, DIST_ONES};
                  test_fill  = 0;
                  train_fill = 0;
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected report %h %h %h", $time,
                        rsp.best_first, rsp.best_second, rsp.best_third);
               fail_count++;
            end else begin
               exp_set = reports_due.pop_front();
               if (rsp.best_first !== exp_set.first) begin
                  $display("%0t: best_first expected %0d got %0d", $time,
                           exp_set.first, rsp.best_first);
                  fail_count++;
               end
               if (rsp.best_second !== exp_set.second) begin
                  $display("%0t: best_second expected %0d got %0d", $time,
                           exp_set.second, rsp.best_second);
                  fail_count++;
               end
               if (rsp.best_third !== exp_set.third) begin
                  $display("%0t: best_third expected %0d got %0d", $time,
                           exp_set.third, rsp.best_third);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the image distortion model distance block.
// Loads a test image, streams whole training images at small warp ranges,
// then random pixel, report and noise transfers with random stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import idm_pkg::*;

   // action code the block must ignore
   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam longint     CYCLE_LIMIT = 4_000_000;
   localparam int         RANDOM_ITEMS = 1100;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [WARP_W-1:0] csr_wr_data;
   int                fail_count;
   int                pending;
   longint            cycle_count = 0;
   bit                no_gap;
   int                train_count;
   logic [GW-1:0]     saved_h [PIX_CNT];
   logic [GW-1:0]     saved_v [PIX_CNT];

   idm_req_if req_bus ();
   idm_rsp_if rsp_bus ();

   image_distortion_model_knn_distance dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   idm_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // guard against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Report receiver: random stalls, one long hold-off early on so that the
   // block backs up and stalls its input, and a stretch with no stalls.
   initial begin
      int taken;
      int stall;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (taken == 4) stall = 600;
         else if (taken >= 12 && taken < 30) stall = 0;
         else stall = $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         taken++;
      end
   end

   function automatic logic [GW-1:0] any_grad();
      return GW'($urandom_range(0, 2047));
   endfunction

   // offer one transfer and hold it until taken, then draw the gap to the next
   task automatic send_item(logic [1:0] act, logic [GW-1:0] gh, logic [GW-1:0] gv);
      int gap;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.grad_h <= gh;
      req_bus.grad_v <= gv;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, let every report drain, then allow the block to settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_warp(logic [WARP_W-1:0] w);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // stream a whole training image; keep it so that it can be replayed
   task automatic train_image(bit replay);
      for (int i = 0; i < PIX_CNT; i++) begin
         if (!replay) begin
            saved_h[i] = any_grad();
            saved_v[i] = any_grad();
         end
         send_item(ACT_TRAIN, saved_h[i], saved_v[i]);
      end
   endtask

   initial begin
      int r;
      no_gap         = 1'b0;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_TEST;
      req_bus.grad_h <= '0;
      req_bus.grad_v <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty report and ignored action before any image is loaded
      send_item(ACT_IGNORED, 11'h7FF, 11'h400);
      send_item(ACT_REPORT, '0, '0);

      // test image with the gradient extremes in its first pixels
      send_item(ACT_TEST, 11'h400, 11'h3FF);
      send_item(ACT_TEST, 11'h3FF, 11'h400);
      send_item(ACT_TEST, 11'h7FF, '0);
      for (int i = 3; i < PIX_CNT; i++) send_item(ACT_TEST, any_grad(), any_grad());
      // wrap past the end: overwrite the first pixels
      send_item(ACT_TEST, 11'h400, 11'h400);
      send_item(ACT_TEST, 11'h3FF, 11'h3FF);
      drain();

      // narrowest window: four images, one a replay to give a tie
      write_warp(WARP_W'(0));
      train_image(1'b0);
      train_image(1'b1);
      train_image(1'b0);
      train_image(1'b0);
      send_item(ACT_REPORT, '0, '0);
      drain();

      // wider windows, the first streamed back to back
      no_gap = 1'b1;
      write_warp(WARP_W'(1));
      train_image(1'b0);
      send_item(ACT_REPORT, '0, '0);
      drain();
      no_gap = 1'b0;
      write_warp(WARP_W'(2));
      train_image(1'b1);
      send_item(ACT_REPORT, '0, '0);
      drain();

      // random traffic: partial training images are cut short by a report,
      // so no window sweep runs at the wide settings
      train_count = 0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 275 == 0) begin
            drain();
            write_warp(k == 0 ? WARP_W'(7) : WARP_W'($urandom_range(3, 7)));
            no_gap = (k == 550);
         end
         r = $urandom_range(0, 99);
         if (r < 9 || (r >= 38 && train_count == PIX_CNT - 1)) begin
            send_item(ACT_REPORT, any_grad(), any_grad());
            train_count = 0;
         end else if (r < 14) begin
            send_item(ACT_IGNORED, any_grad(), any_grad());
         end else if (r < 38) begin
            send_item(ACT_TEST, any_grad(), any_grad());
         end else begin
            send_item(ACT_TRAIN, any_grad(), any_grad());
            train_count++;
         end
      end
      send_item(ACT_REPORT, '0, '0);
      drain();
      repeat (50) @(posedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
